### hdl/alkd_pkg.sv
package alkd_pkg;

  localparam int ADC_BITS   = 10;
  localparam int TIME_BITS  = 32;
  localparam int CENTER_W   = 10;
  localparam int WIN_W      = 8;
  localparam int DEB_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_KEYS   = 5;
  localparam int KEY_W      = 3;

  // compare width: wide enough for centre plus window without wrapping
  localparam int CMP_W = ((ADC_BITS > CENTER_W) ? ADC_BITS : CENTER_W) + 1;

  localparam logic [KEY_W-1:0] KEY_NONE   = 3'd0;
  localparam logic [KEY_W-1:0] KEY_RIGHT  = 3'd1;
  localparam logic [KEY_W-1:0] KEY_UP     = 3'd2;
  localparam logic [KEY_W-1:0] KEY_DOWN   = 3'd3;
  localparam logic [KEY_W-1:0] KEY_LEFT   = 3'd4;
  localparam logic [KEY_W-1:0] KEY_SELECT = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_CENTER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_CENTER     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_CENTER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_CENTER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SELECT_CENTER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SENSE_WINDOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd6;

  localparam logic [CENTER_W-1:0] RST_RIGHT_CENTER  = 10'd0;
  localparam logic [CENTER_W-1:0] RST_UP_CENTER     = 10'd145;
  localparam logic [CENTER_W-1:0] RST_DOWN_CENTER   = 10'd329;
  localparam logic [CENTER_W-1:0] RST_LEFT_CENTER   = 10'd505;
  localparam logic [CENTER_W-1:0] RST_SELECT_CENTER = 10'd741;
  localparam logic [WIN_W-1:0]    RST_SENSE_WINDOW  = 8'd10;
  localparam logic [DEB_W-1:0]    RST_DEBOUNCE_MS   = 16'd50;

  // centre entry 0 is right, then up, down, left, select
  typedef struct packed {
    logic [NUM_KEYS-1:0][CENTER_W-1:0] center;
    logic [WIN_W-1:0]                  window;
    logic [DEB_W-1:0]                  debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             pressed;
    logic             released;
  } res_t;

endpackage

### hdl/alkd_classify.sv
module alkd_classify (
  input  alkd_pkg::cfg_t                   cfg,
  input  logic [alkd_pkg::ADC_BITS-1:0]    adc_sample,
  output logic [alkd_pkg::KEY_W-1:0]       raw_key
);

  always_comb begin
    logic [alkd_pkg::CMP_W-1:0] sample_ext;
    logic [alkd_pkg::CMP_W-1:0] win_ext;
    logic [alkd_pkg::CMP_W-1:0] c_ext;
    logic [alkd_pkg::CMP_W-1:0] lo;
    logic [alkd_pkg::CMP_W-1:0] hi;
    sample_ext = alkd_pkg::CMP_W'(adc_sample);
    win_ext    = alkd_pkg::CMP_W'(cfg.window);
    raw_key    = alkd_pkg::KEY_NONE;
    // walk from the last key down so the earliest match is kept
    for (int k = alkd_pkg::NUM_KEYS - 1; k >= 1; k--) begin
      c_ext = alkd_pkg::CMP_W'(cfg.center[k]);
      lo    = (c_ext > win_ext) ? (c_ext - win_ext) : '0;
      hi    = c_ext + win_ext;
      if (sample_ext >= lo && sample_ext <= hi) begin
        raw_key = alkd_pkg::KEY_W'(k + 1);
      end
    end
    // right key takes everything below its upper bound
    c_ext = alkd_pkg::CMP_W'(cfg.center[0]);
    if (sample_ext < c_ext + win_ext) begin
      raw_key = alkd_pkg::KEY_RIGHT;
    end
  end

endmodule

### hdl/alkd_debounce.sv
module alkd_debounce (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             advance,
  input  logic [alkd_pkg::KEY_W-1:0]       raw_key,
  input  logic [alkd_pkg::TIME_BITS-1:0]   now_ms,
  input  logic [alkd_pkg::DEB_W-1:0]       debounce_ms,
  output alkd_pkg::res_t                   res
);

  logic [alkd_pkg::KEY_W-1:0]     last_raw_r;
  logic [alkd_pkg::TIME_BITS-1:0] change_time_r, change_time_nxt;
  logic [alkd_pkg::KEY_W-1:0]     last_rep_r;
  logic                           pressed_r, pressed_nxt;
  logic                           released_r, released_nxt;
  logic [alkd_pkg::TIME_BITS-1:0] elapsed;
  logic [alkd_pkg::KEY_W-1:0]     rep_key;

  assign elapsed = now_ms - change_time_r;

  always_comb begin
    rep_key         = alkd_pkg::KEY_NONE;
    change_time_nxt = change_time_r;
    if (raw_key != alkd_pkg::KEY_NONE) begin
      if (raw_key == last_raw_r) begin
        if (elapsed > alkd_pkg::TIME_BITS'(debounce_ms)) begin
          rep_key = raw_key;
        end
      end else begin
        change_time_nxt = now_ms;
      end
    end

    pressed_nxt  = pressed_r;
    released_nxt = released_r;
    if (last_rep_r == alkd_pkg::KEY_NONE && rep_key != alkd_pkg::KEY_NONE) begin
      pressed_nxt  = 1'b1;
      released_nxt = 1'b0;
    end
    if (last_rep_r != alkd_pkg::KEY_NONE && rep_key == alkd_pkg::KEY_NONE) begin
      pressed_nxt  = 1'b0;
      released_nxt = 1'b1;
    end
  end

  assign res.key      = rep_key;
  assign res.pressed  = pressed_nxt;
  assign res.released = released_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r    <= alkd_pkg::KEY_NONE;
      change_time_r <= '0;
      last_rep_r    <= alkd_pkg::KEY_NONE;
      pressed_r     <= 1'b0;
      released_r    <= 1'b0;
    end else if (advance) begin
      last_raw_r    <= raw_key;
      change_time_r <= change_time_nxt;
      last_rep_r    <= rep_key;
      pressed_r     <= pressed_nxt;
      released_r    <= released_nxt;
    end
  end

endmodule

### hdl/analog_ladder_keypad_debounce.sv
// Keypad decoder for a resistor ladder: each request carries one ADC sample and the current
// millisecond count and produces exactly one result (debounced key code plus held pressed and
// released flags). One request is taken every clock cycle while in_ready is high; an accepted
// request is held in the input register and then loaded into the result register, with the
// key classification and the 32-bit elapsed-time compare between them. Flow control on the
// output side stalls the input only when both registers are full. Configuration registers are
// written through cfg_we, cfg_index and cfg_wdata; the user must write them only while no
// request is in flight, as the block itself does not enforce this.
module analog_ladder_keypad_debounce (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [alkd_pkg::ADC_BITS-1:0]      in_adc_sample,
  input  logic [alkd_pkg::TIME_BITS-1:0]     in_now_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [alkd_pkg::KEY_W-1:0]         out_key_code,
  output logic                               out_pressed_flag,
  output logic                               out_released_flag,
  input  logic                               cfg_we,
  input  logic [alkd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [alkd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  alkd_pkg::cfg_t                 cfg_r;
  logic                           s1_valid_r;
  logic [alkd_pkg::ADC_BITS-1:0]  s1_adc_r;
  logic [alkd_pkg::TIME_BITS-1:0] s1_now_r;
  logic                           out_valid_r;
  alkd_pkg::res_t                 out_res_r;
  logic                           advance;
  logic [alkd_pkg::KEY_W-1:0]     raw_key;
  alkd_pkg::res_t                 res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center[0]   <= alkd_pkg::RST_RIGHT_CENTER;
      cfg_r.center[1]   <= alkd_pkg::RST_UP_CENTER;
      cfg_r.center[2]   <= alkd_pkg::RST_DOWN_CENTER;
      cfg_r.center[3]   <= alkd_pkg::RST_LEFT_CENTER;
      cfg_r.center[4]   <= alkd_pkg::RST_SELECT_CENTER;
      cfg_r.window      <= alkd_pkg::RST_SENSE_WINDOW;
      cfg_r.debounce_ms <= alkd_pkg::RST_DEBOUNCE_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        alkd_pkg::REG_RIGHT_CENTER:
          cfg_r.center[0] <= cfg_wdata[alkd_pkg::CENTER_W-1:0];
        alkd_pkg::REG_UP_CENTER:
          cfg_r.center[1] <= cfg_wdata[alkd_pkg::CENTER_W-1:0];
        alkd_pkg::REG_DOWN_CENTER:
          cfg_r.center[2] <= cfg_wdata[alkd_pkg::CENTER_W-1:0];
        alkd_pkg::REG_LEFT_CENTER:
          cfg_r.center[3] <= cfg_wdata[alkd_pkg::CENTER_W-1:0];
        alkd_pkg::REG_SELECT_CENTER:
          cfg_r.center[4] <= cfg_wdata[alkd_pkg::CENTER_W-1:0];
        alkd_pkg::REG_SENSE_WINDOW:
          cfg_r.window <= cfg_wdata[alkd_pkg::WIN_W-1:0];
        alkd_pkg::REG_DEBOUNCE_MS:
          cfg_r.debounce_ms <= cfg_wdata[alkd_pkg::DEB_W-1:0];
        default: begin
          // index past the register list is ignored
        end
      endcase
    end
  end

  // stage one moves on when the result register is free or being drained
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_adc_r <= in_adc_sample;
      s1_now_r <= in_now_ms;
    end
  end

  alkd_classify u_classify (
    .cfg        (cfg_r),
    .adc_sample (s1_adc_r),
    .raw_key    (raw_key)
  );

  alkd_debounce u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .raw_key     (raw_key),
    .now_ms      (s1_now_r),
    .debounce_ms (cfg_r.debounce_ms),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_key_code      = out_res_r.key;
  assign out_pressed_flag  = out_res_r.pressed;
  assign out_released_flag = out_res_r.released;

endmodule
